// ===== rtl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

  // Request codes carried in tuser of the input stream
  localparam logic [2:0] REQ_NONE  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_WRITE = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  // Phase codes
  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;

  // Last bit index of a byte
  localparam logic [3:0] LAST_BIT = 4'd7;

  localparam logic [15:0] SPACER_RESET = 16'd100;

  // Configuration register indexes
  localparam logic REG_SPACER = 1'b0;

  // One input word, unpacked
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_sample;
  } in_item_t;

  // One result word, unpacked
  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/i2cms_core.sv =====
`default_nettype none

// Sequencer state and one-tick update
module i2cms_core #(
  parameter int unsigned CLEAR_PULSES = 9
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  i2cms_pkg::in_item_t  item_i,
  input  wire [15:0]           spacer_i,
  output i2cms_pkg::out_item_t result_o
);

  localparam logic [3:0] ClearLast = 4'(CLEAR_PULSES - 1);

  logic [2:0]  cmd_q, cmd_d;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] delay_q, delay_d;
  logic        scl_q, scl_d;
  logic        oe_q, oe_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic        nack_q, nack_d;
  logic [7:0]  rx_q, rx_d;

  logic [15:0] spacer_load;
  logic [15:0] delay_dec;
  logic        fin;
  logic        done;

  assign spacer_load = (spacer_i == 16'd0) ? 16'd1 : spacer_i;
  assign delay_dec   = (delay_q != 16'd0) ? delay_q - 16'd1 : delay_q;

  // Next state for one tick
  always_comb begin
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    scl_d     = scl_q;
    oe_d      = oe_q;
    sda_d     = sda_q;
    ack_d     = ack_q;
    nack_d    = nack_q;
    rx_d      = rx_q;
    fin       = 1'b0;
    done      = 1'b0;

    if (cmd_q == i2cms_pkg::REQ_NONE) begin
      // Idle: take a new command, first segment happens now
      if (item_i.req_type inside {[i2cms_pkg::REQ_START : i2cms_pkg::REQ_READ]}) begin
        cmd_d     = item_i.req_type;
        phase_d   = i2cms_pkg::PH_0;
        bit_cnt_d = 4'd0;
        delay_d   = spacer_load;
        case (item_i.req_type)
          i2cms_pkg::REQ_START, i2cms_pkg::REQ_STOP: begin
            oe_d  = 1'b1;
            sda_d = 1'b0;
          end
          i2cms_pkg::REQ_CLEAR: begin
            oe_d  = 1'b1;
            sda_d = 1'b1;
            scl_d = 1'b1;
          end
          i2cms_pkg::REQ_WRITE: begin
            shift_d = item_i.data_byte;
            oe_d    = 1'b1;
            sda_d   = item_i.data_byte[7];
          end
          default: begin
            shift_d = 8'd0;
            ack_d   = item_i.ack_to_send;
            oe_d    = 1'b0;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
          end
        endcase
      end
    end else begin
      delay_d = delay_dec;
      if (delay_dec == 16'd0) begin
        // Spacer ran out: next pin-change segment
        case (cmd_q)
          i2cms_pkg::REQ_START: begin
            if (phase_q == i2cms_pkg::PH_0) begin
              scl_d   = 1'b0;
              phase_d = i2cms_pkg::PH_1;
            end else begin
              fin = 1'b1;
            end
          end
          i2cms_pkg::REQ_STOP: begin
            if (phase_q == i2cms_pkg::PH_0) begin
              scl_d   = 1'b1;
              phase_d = i2cms_pkg::PH_1;
            end else if (phase_q == i2cms_pkg::PH_1) begin
              sda_d   = 1'b1;
              phase_d = i2cms_pkg::PH_2;
            end else begin
              fin = 1'b1;
            end
          end
          i2cms_pkg::REQ_CLEAR: begin
            if (phase_q == i2cms_pkg::PH_0) begin
              scl_d   = 1'b0;
              phase_d = i2cms_pkg::PH_1;
            end else if (bit_cnt_q >= ClearLast) begin
              fin = 1'b1;
            end else begin
              bit_cnt_d = bit_cnt_q + 4'd1;
              scl_d     = 1'b1;
              phase_d   = i2cms_pkg::PH_0;
            end
          end
          i2cms_pkg::REQ_WRITE: begin
            case (phase_q)
              i2cms_pkg::PH_0: begin
                scl_d   = 1'b1;
                phase_d = i2cms_pkg::PH_1;
              end
              i2cms_pkg::PH_1: begin
                scl_d   = 1'b0;
                phase_d = i2cms_pkg::PH_2;
              end
              i2cms_pkg::PH_2: begin
                if (bit_cnt_q >= i2cms_pkg::LAST_BIT) begin
                  // release SDA for the ACK slot
                  oe_d    = 1'b0;
                  sda_d   = 1'b1;
                  scl_d   = 1'b1;
                  phase_d = i2cms_pkg::PH_3;
                end else begin
                  bit_cnt_d = bit_cnt_q + 4'd1;
                  shift_d   = {shift_q[6:0], 1'b0};
                  sda_d     = shift_q[6];
                  phase_d   = i2cms_pkg::PH_0;
                end
              end
              i2cms_pkg::PH_3: begin
                nack_d  = item_i.sda_sample;
                scl_d   = 1'b0;
                oe_d    = 1'b1;
                phase_d = i2cms_pkg::PH_4;
              end
              default: fin = 1'b1;
            endcase
          end
          i2cms_pkg::REQ_READ: begin
            case (phase_q)
              i2cms_pkg::PH_0: begin
                shift_d = {shift_q[6:0], item_i.sda_sample};
                scl_d   = 1'b0;
                phase_d = i2cms_pkg::PH_1;
              end
              i2cms_pkg::PH_1: begin
                if (bit_cnt_q >= i2cms_pkg::LAST_BIT) begin
                  oe_d    = 1'b1;
                  sda_d   = ~ack_q;
                  scl_d   = 1'b1;
                  phase_d = i2cms_pkg::PH_2;
                end else begin
                  bit_cnt_d = bit_cnt_q + 4'd1;
                  scl_d     = 1'b1;
                  phase_d   = i2cms_pkg::PH_0;
                end
              end
              i2cms_pkg::PH_2: begin
                scl_d   = 1'b0;
                phase_d = i2cms_pkg::PH_3;
              end
              default: begin
                oe_d  = 1'b0;
                sda_d = 1'b1;
                rx_d  = shift_q;
                fin   = 1'b1;
              end
            endcase
          end
          default: fin = 1'b1;
        endcase

        if (fin) begin
          cmd_d     = i2cms_pkg::REQ_NONE;
          phase_d   = i2cms_pkg::PH_0;
          bit_cnt_d = 4'd0;
          done      = 1'b1;
        end else begin
          delay_d = spacer_load;
        end
      end
    end
  end

  // Result word reflects the state after this tick
  always_comb begin
    result_o.scl_level = scl_d;
    result_o.sda_drive = oe_d;
    result_o.sda_level = sda_d;
    result_o.busy_res  = (cmd_d != i2cms_pkg::REQ_NONE);
    result_o.done_res  = done;
    result_o.read_data = rx_d;
    result_o.nack_seen = nack_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= i2cms_pkg::REQ_NONE;
      phase_q   <= i2cms_pkg::PH_0;
      bit_cnt_q <= 4'd0;
      shift_q   <= 8'd0;
      delay_q   <= 16'd0;
      scl_q     <= 1'b1;
      oe_q      <= 1'b1;
      sda_q     <= 1'b1;
      ack_q     <= 1'b0;
      nack_q    <= 1'b0;
      rx_q      <= 8'd0;
    end else if (step_i) begin
      cmd_q     <= cmd_d;
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      delay_q   <= delay_d;
      scl_q     <= scl_d;
      oe_q      <= oe_d;
      sda_q     <= sda_d;
      ack_q     <= ack_d;
      nack_q    <= nack_d;
      rx_q      <= rx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_sequencer.sv =====
// Channel  | Dir | Handshake                  | Payload
// s_axis   | in  | s_axis_tvalid/tready       | tdata: tick word, tuser: request code
// m_axis   | out | m_axis_tvalid/tready       | tdata: pin and status word
// apb      | in  | psel/penable, pready = 1   | spacer_ticks at address 0
//
// One tick word per cycle sustained unless the output stalls; an accepted word
// passes the input register, then sequencer update into the result register.
// The sequencer state advances only when a word moves from the input register
// into the result register, so a stalled output holds both stages.
// Reset is asynchronous, active low; spacer_ticks resets to 100.
`default_nettype none

module i2c_master_bit_sequencer #(
  parameter int unsigned CLEAR_PULSES = 9
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // input tick stream
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [15:0] s_axis_tdata,  // [7:0] data_byte, [8] ack_to_send, [9] sda_sample
  input  wire [2:0]  s_axis_tuser,  // [2:0] req_type
  // result stream
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata, // [0] scl_level, [1] sda_drive, [2] sda_level,
                                    // [3] busy_res, [4] done_res, [12:5] read_data,
                                    // [13] nack_seen
  // configuration
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  logic                 in_v_q;
  i2cms_pkg::in_item_t  in_q;
  logic                 out_v_q;
  i2cms_pkg::out_item_t out_q;
  i2cms_pkg::out_item_t result;
  logic [15:0]          spacer_q;
  logic                 step;
  logic                 cfg_wr;

  // A word moves on when the result register is free or being drained
  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.req_type    <= s_axis_tuser;
      in_q.data_byte   <= s_axis_tdata[7:0];
      in_q.ack_to_send <= s_axis_tdata[8];
      in_q.sda_sample  <= s_axis_tdata[9];
    end
  end

  i2cms_core #(
    .CLEAR_PULSES(CLEAR_PULSES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .spacer_i(spacer_q),
    .result_o(result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q.nack_seen, out_q.read_data, out_q.done_res,
                          out_q.busy_res, out_q.sda_level, out_q.sda_drive,
                          out_q.scl_level};

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacer_q <= i2cms_pkg::SPACER_RESET;
    end else if (cfg_wr && (paddr[2] == i2cms_pkg::REG_SPACER)) begin
      spacer_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == i2cms_pkg::REG_SPACER) ? {16'd0, spacer_q} : 32'd0;

`ifndef NO_ASSERTIONS
  // a finishing tick always reports the bus as no longer busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
    else $error("done word still reports busy");

  // input stalls only when both stages are full and the output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_v_q && out_v_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  // a drained result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !in_v_q |=> !m_axis_tvalid)
    else $error("result repeated after drain");
`endif

endmodule

`default_nettype wire
